// ===== src/tlpd_pkg.sv =====
// tlpd_pkg: shared types and constants for the tree path engine.
// No dependencies; used by the interfaces, the register block, the top and the checker.
package tlpd_pkg;

	localparam int NODE_W   = 11;
	localparam int WEIGHT_W = 16;
	localparam int DIST_W   = 26;
	localparam int STATUS_W = 2;
	localparam int KIND_W   = 2;

	localparam int MAX_NODES_DEF    = 1024;
	localparam int TABLE_LEVELS_DEF = 11;
	localparam int WEIGHT_BITS_DEF  = 16;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR = 2'd0,
		KIND_EDGE  = 2'd1,
		KIND_BUILD = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_NODE  = 2'd1,
		ST_NOT_BUILT = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_NODE_COUNT = 1'b0,
		REG_ROOT_NODE  = 1'b1
	} reg_idx_t;

	localparam logic [NODE_W-1:0] NODE_COUNT_RST = 11'd1;
	localparam logic [NODE_W-1:0] ROOT_NODE_RST  = 11'd1;

	typedef struct packed {
		logic [NODE_W-1:0] node_count;
		logic [NODE_W-1:0] root_node;
	} cfg_t;

endpackage

// ===== src/tlpd_if.sv =====
// tlpd_cmd_if / tlpd_res_if: valid/ready channels of the tree path engine.
// Depends on tlpd_pkg for field widths.
interface tlpd_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [tlpd_pkg::KIND_W-1:0]      kind;
	logic [tlpd_pkg::NODE_W-1:0]      node_a;
	logic [tlpd_pkg::NODE_W-1:0]      node_b;
	logic [tlpd_pkg::WEIGHT_W-1:0]    edge_weight;

	modport source (output valid, kind, node_a, node_b, edge_weight, input ready);
	modport sink   (input valid, kind, node_a, node_b, edge_weight, output ready);
endinterface

interface tlpd_res_if;
	logic                             valid;
	logic                             ready;
	logic [tlpd_pkg::NODE_W-1:0]      ancestor;
	logic [tlpd_pkg::DIST_W-1:0]      distance;
	logic [tlpd_pkg::STATUS_W-1:0]    status;

	modport source (output valid, ancestor, distance, status, input ready);
	modport sink   (input valid, ancestor, distance, status, output ready);
endinterface

// ===== src/tlpd_cfg.sv =====
// tlpd_cfg: APB register block holding node_count and root_node.
// Depends on tlpd_pkg.
module tlpd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tlpd_pkg::APB_AW-1:0]   paddr,
	input  logic [tlpd_pkg::APB_DW-1:0]   pwdata,
	output logic [tlpd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output tlpd_pkg::cfg_t                cfg
);

	tlpd_pkg::cfg_t     cfg_q;
	tlpd_pkg::reg_idx_t idx;
	logic               wr;

	assign idx    = tlpd_pkg::reg_idx_t'(paddr[2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_count <= tlpd_pkg::NODE_COUNT_RST;
			cfg_q.root_node  <= tlpd_pkg::ROOT_NODE_RST;
		end else if (wr) begin
			case (idx)
				tlpd_pkg::REG_NODE_COUNT: cfg_q.node_count <= pwdata[tlpd_pkg::NODE_W-1:0];
				tlpd_pkg::REG_ROOT_NODE:  cfg_q.root_node  <= pwdata[tlpd_pkg::NODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tlpd_pkg::REG_NODE_COUNT: prdata = tlpd_pkg::APB_DW'(cfg_q.node_count);
			tlpd_pkg::REG_ROOT_NODE:  prdata = tlpd_pkg::APB_DW'(cfg_q.root_node);
			default:                  prdata = '0;
		endcase
	end

endmodule

// ===== src/tree_lca_path_distance.sv =====
// tree_lca_path_distance: weighted tree LCA and path distance (Euler tour + sparse table).
// Depends on tlpd_pkg, tlpd_if (tlpd_cmd_if, tlpd_res_if) and tlpd_cfg.
//
//   channel | dir | handshake        | word
//   cmd     | in  | valid/ready      | kind, node_a, node_b, edge_weight
//   res     | out | valid/ready      | ancestor, distance, status
//   apb     | in  | psel/penable     | paddr, pwdata -> node_count, root_node
//
// Edge word: S_E_WRA, S_E_RDB, S_E_WRB. Query: paced by the chain of registered
// memory reads (node info, sparse table, tour, node info).
// Clear: sweeps first_edge. Build: sweeps visited, then sets up the root if valid,
// then walks the tree, scanning adjacency entries, pushing unvisited nodes and
// popping, then fills the sparse table level by level.
// After reset a sweep runs with cmd.ready low.
// A query result waits in the output register; cmd is taken meanwhile.
module tree_lca_path_distance #(
	parameter int MAX_NODES    = tlpd_pkg::MAX_NODES_DEF,
	parameter int TABLE_LEVELS = tlpd_pkg::TABLE_LEVELS_DEF,
	parameter int WEIGHT_BITS  = tlpd_pkg::WEIGHT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tlpd_cmd_if.sink                      cmd,
	tlpd_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tlpd_pkg::APB_AW-1:0]   paddr,
	input  logic [tlpd_pkg::APB_DW-1:0]   pwdata,
	output logic [tlpd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int NODE_AW  = $clog2(MAX_NODES + 1);
	localparam int NODE_D   = MAX_NODES + 1;
	localparam int EDGE_CAP = 2 * MAX_NODES;
	localparam int EDGE_AW  = $clog2(EDGE_CAP + 1);
	localparam int EDGE_IW  = $clog2(EDGE_CAP);
	localparam int TOUR_CAP = 2 * MAX_NODES;
	localparam int TOUR_AW  = $clog2(TOUR_CAP);
	localparam int TL_W     = $clog2(TOUR_CAP + 1);
	localparam int SP_W     = $clog2(MAX_NODES + 1);
	localparam int STK_AW   = $clog2(MAX_NODES);
	localparam int LVL_W    = $clog2(TABLE_LEVELS);
	localparam int WB       = (WEIGHT_BITS < tlpd_pkg::WEIGHT_W) ? WEIGHT_BITS
	                                                             : tlpd_pkg::WEIGHT_W;
	localparam int DWI      = WB + NODE_AW;
	localparam int IW       = (NODE_AW > tlpd_pkg::NODE_W) ? NODE_AW : tlpd_pkg::NODE_W;
	localparam int CMP_W    = ((TL_W > TABLE_LEVELS) ? TL_W : TABLE_LEVELS) + 1;
	localparam int SW       = (DWI + 1 > tlpd_pkg::DIST_W) ? DWI + 1 : tlpd_pkg::DIST_W;

	typedef struct packed {
		logic [NODE_AW-1:0] tgt;
		logic [WB-1:0]      w;
		logic [EDGE_AW-1:0] nxt;
	} adj_t;

	typedef struct packed {
		logic               vis;
		logic [DWI-1:0]     rsum;
		logic [TOUR_AW-1:0] fv;
	} info_t;

	typedef struct packed {
		logic [NODE_AW-1:0] node;
		logic [EDGE_AW-1:0] edg;
		logic [DWI-1:0]     rsum;
	} stk_t;

	typedef struct packed {
		logic [NODE_AW-1:0] node;
		logic [SP_W-1:0]    depth;
	} tour_t;

	typedef struct packed {
		logic [TOUR_AW-1:0] pos;
		logic [SP_W-1:0]    depth;
	} rmq_t;

	typedef enum logic [17:0] {
		S_SWEEP    = 18'h00001,
		S_IDLE     = 18'h00002,
		S_E_WRA    = 18'h00004,
		S_E_RDB    = 18'h00008,
		S_E_WRB    = 18'h00010,
		S_ROOT     = 18'h00020,
		S_ROOT_FE  = 18'h00040,
		S_W_TOP    = 18'h00080,
		S_W_ADJ    = 18'h00100,
		S_W_VISIT  = 18'h00200,
		S_W_POPD   = 18'h00400,
		S_FILL     = 18'h00800,
		S_FILL_GAP = 18'h01000,
		S_Q_INFO   = 18'h02000,
		S_Q_TABLE  = 18'h04000,
		S_Q_TOUR   = 18'h08000,
		S_Q_DIST   = 18'h10000,
		S_Q_OUT    = 18'h20000
	} state_t;

	function automatic rmq_t pick(input rmq_t p, input rmq_t q);
		return (p.depth < q.depth) ? p : q;
	endfunction

	function automatic logic [LVL_W-1:0] flog2(input logic [TOUR_AW:0] v);
		int k;
		k = 0;
		for (int b = 0; b <= TOUR_AW; b++) begin
			if (v[b]) k = b;
		end
		if (k > TABLE_LEVELS - 1) k = TABLE_LEVELS - 1;
		return LVL_W'(k);
	endfunction

	// ---------------- configuration
	tlpd_pkg::cfg_t cfg;

	tlpd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [IW-1:0] lim;
	logic [IW-1:0] nc_ext;

	assign nc_ext = IW'(cfg.node_count);
	assign lim    = (nc_ext > IW'(MAX_NODES)) ? IW'(MAX_NODES) : nc_ext;

	function automatic logic in_lim(input logic [IW-1:0] v, input logic [IW-1:0] l);
		return (v != '0) && (v <= l);
	endfunction

	// ---------------- sequencer registers
	state_t              state_q;
	logic                sweep_fe_q, sweep_vis_q, build_q, ready_q;
	logic [NODE_AW-1:0]  swp_q;
	logic [EDGE_AW-1:0]  ec_q;
	logic [TL_W-1:0]     tl_q;
	logic [SP_W-1:0]     sp_q;
	logic [NODE_AW-1:0]  top_node_q;
	logic [EDGE_AW-1:0]  top_edge_q;
	logic [DWI-1:0]      top_dist_q;
	logic [NODE_AW-1:0]  a_q, b_q, v_q, anc_q;
	logic [WB-1:0]       w_q;
	logic [DWI-1:0]      da_q, db_q;
	logic [TL_W-1:0]     i_q;
	logic [LVL_W-1:0]    lvl_q;
	logic                fill_s1;
	logic [TOUR_AW-1:0]  i_s1;
	logic [LVL_W-1:0]    lvl_s1;
	logic [tlpd_pkg::NODE_W-1:0]   rs_anc_q, out_anc_q;
	logic [tlpd_pkg::DIST_W-1:0]   rs_dist_q, out_dist_q;
	tlpd_pkg::status_t             rs_stat_q, out_stat_q;
	logic                          out_valid_q;

	// ---------------- memory ports
	logic               fe_we;
	logic [NODE_AW-1:0] fe_wa, fe_ra;
	logic [EDGE_AW-1:0] fe_wd, fe_rd;

	logic               adj_we;
	logic [EDGE_IW-1:0] adj_wa, adj_ra;
	adj_t               adj_wd, adj_rd;

	logic               inf_we;
	logic [NODE_AW-1:0] inf_wa, inf_raa, inf_rab;
	info_t              inf_wd, inf_rda, inf_rdb;

	logic               stk_we;
	logic [STK_AW-1:0]  stk_wa, stk_ra;
	stk_t               stk_wd, stk_rd;

	logic               tour_we;
	logic [TOUR_AW-1:0] tour_wa, tour_ra;
	tour_t              tour_wd, tour_rd;

	logic               rmq_we;
	logic [LVL_W-1:0]   rmq_wl, rmq_rl;
	logic [TOUR_AW-1:0] rmq_wa, rmq_ra0, rmq_ra1;
	rmq_t               rmq_wd, rmq_rd0, rmq_rd1;

	logic [EDGE_AW-1:0] fe_mem   [NODE_D];
	adj_t               adj_mem  [EDGE_CAP];
	info_t              inf_mem  [NODE_D];
	stk_t               stk_mem  [MAX_NODES];
	tour_t              tour_mem [TOUR_CAP];
	rmq_t               rmq_mem  [TABLE_LEVELS][TOUR_CAP];

	always_ff @(posedge clk) begin
		if (fe_we) fe_mem[fe_wa] <= fe_wd;
		fe_rd <= fe_mem[fe_ra];
	end

	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_wa] <= adj_wd;
		adj_rd <= adj_mem[adj_ra];
	end

	always_ff @(posedge clk) begin
		if (inf_we) inf_mem[inf_wa] <= inf_wd;
		inf_rda <= inf_mem[inf_raa];
		inf_rdb <= inf_mem[inf_rab];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		stk_rd <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk) begin
		if (tour_we) tour_mem[tour_wa] <= tour_wd;
		tour_rd <= tour_mem[tour_ra];
	end

	always_ff @(posedge clk) begin
		if (rmq_we) rmq_mem[rmq_wl][rmq_wa] <= rmq_wd;
		rmq_rd0 <= rmq_mem[rmq_rl][rmq_ra0];
		rmq_rd1 <= rmq_mem[rmq_rl][rmq_ra1];
	end

	// ---------------- derived values
	logic [IW-1:0]       cmd_a_ext, cmd_b_ext, root_ext, tgt_ext;
	logic [NODE_AW-1:0]  cmd_a_idx, cmd_b_idx, root_idx;
	logic                edge_ok, root_ok, top_done, can_push, tl_room;
	logic [SP_W-1:0]     sp_m1, sp_m2;
	logic [CMP_W-1:0]    span, half, i_ext, rd1_ext;
	logic                fill_go;
	logic [TOUR_AW-1:0]  qx, qy;
	logic [TOUR_AW:0]    qlen, qy1;
	logic [LVL_W-1:0]    qk;
	rmq_t                qpick;
	logic [DWI:0]        qs, qt, qd;
	logic [SW-1:0]       qd_ext;
	logic                accept;

	assign cmd_a_ext = IW'(cmd.node_a);
	assign cmd_b_ext = IW'(cmd.node_b);
	assign root_ext  = IW'(cfg.root_node);
	assign tgt_ext   = IW'(adj_rd.tgt);
	assign cmd_a_idx = NODE_AW'(cmd.node_a);
	assign cmd_b_idx = NODE_AW'(cmd.node_b);
	assign root_idx  = NODE_AW'(cfg.root_node);

	assign edge_ok = in_lim(cmd_a_ext, IW'(MAX_NODES)) && in_lim(cmd_b_ext, IW'(MAX_NODES))
	                 && (({1'b0, ec_q} + (EDGE_AW+1)'(2)) <= (EDGE_AW+1)'(EDGE_CAP));
	assign root_ok  = in_lim(root_ext, lim);
	assign top_done = top_edge_q >= EDGE_AW'(EDGE_CAP);
	assign can_push = in_lim(tgt_ext, lim) && (sp_q < SP_W'(MAX_NODES));
	assign tl_room  = tl_q < TL_W'(TOUR_CAP);
	assign sp_m1    = sp_q - SP_W'(1);
	assign sp_m2    = sp_q - SP_W'(2);

	assign span    = CMP_W'(1) << lvl_q;
	assign half    = span >> 1;
	assign i_ext   = CMP_W'(i_q);
	assign rd1_ext = i_ext + half;
	assign fill_go = (lvl_q == '0) ? (i_q < tl_q) : ((i_ext + span) <= CMP_W'(tl_q));

	assign qx    = (inf_rda.fv > inf_rdb.fv) ? inf_rdb.fv : inf_rda.fv;
	assign qy    = (inf_rda.fv > inf_rdb.fv) ? inf_rda.fv : inf_rdb.fv;
	assign qlen  = {1'b0, qy} - {1'b0, qx} + (TOUR_AW+1)'(1);
	assign qk    = flog2(qlen);
	assign qy1   = {1'b0, qy} + (TOUR_AW+1)'(1) - ((TOUR_AW+1)'(1) << qk);
	assign qpick = pick(rmq_rd0, rmq_rd1);

	assign qs     = {1'b0, da_q} + {1'b0, db_q};
	assign qt     = {inf_rdb.rsum, 1'b0};
	assign qd     = (qs >= qt) ? (qs - qt) : '0;
	assign qd_ext = SW'(qd);

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);

	assign res.valid    = out_valid_q;
	assign res.ancestor = out_anc_q;
	assign res.distance = out_dist_q;
	assign res.status   = out_stat_q;

	// ---------------- memory port control
	always_comb begin
		fe_we   = 1'b0;
		fe_wa   = a_q;
		fe_wd   = ec_q;
		fe_ra   = a_q;
		adj_we  = 1'b0;
		adj_wa  = ec_q[EDGE_IW-1:0];
		adj_wd  = '{tgt: b_q, w: w_q, nxt: fe_rd};
		adj_ra  = top_edge_q[EDGE_IW-1:0];
		inf_we  = 1'b0;
		inf_wa  = v_q;
		inf_wd  = '{vis: 1'b1, rsum: top_dist_q + DWI'(w_q), fv: tl_q[TOUR_AW-1:0]};
		inf_raa = cmd_a_idx;
		inf_rab = cmd_b_idx;
		stk_we  = 1'b0;
		stk_wa  = sp_m1[STK_AW-1:0];
		stk_wd  = '{node: top_node_q, edg: top_edge_q, rsum: top_dist_q};
		stk_ra  = sp_m2[STK_AW-1:0];
		tour_we = 1'b0;
		tour_wa = tl_q[TOUR_AW-1:0];
		tour_wd = '{node: v_q, depth: sp_q};
		tour_ra = i_q[TOUR_AW-1:0];
		rmq_we  = fill_s1;
		rmq_wl  = lvl_s1;
		rmq_wa  = i_s1;
		rmq_wd  = (lvl_s1 == '0) ? rmq_t'{pos: i_s1, depth: tour_rd.depth}
		                         : pick(rmq_rd0, rmq_rd1);
		rmq_rl  = lvl_q - LVL_W'(1);
		rmq_ra0 = i_q[TOUR_AW-1:0];
		rmq_ra1 = rd1_ext[TOUR_AW-1:0];
		case (state_q)
			S_SWEEP: begin
				fe_we  = sweep_fe_q;
				fe_wa  = swp_q;
				fe_wd  = EDGE_AW'(EDGE_CAP);
				inf_we = sweep_vis_q;
				inf_wa = swp_q;
				inf_wd = '0;
			end
			S_IDLE: begin
				fe_ra = cmd_a_idx;
			end
			S_E_WRA: begin
				fe_we  = 1'b1;
				adj_we = 1'b1;
			end
			S_E_RDB: begin
				fe_ra = b_q;
			end
			S_E_WRB: begin
				fe_we  = 1'b1;
				fe_wa  = b_q;
				adj_we = 1'b1;
				adj_wd = '{tgt: a_q, w: w_q, nxt: fe_rd};
			end
			S_ROOT: begin
				fe_ra   = root_idx;
				inf_we  = root_ok;
				inf_wa  = root_idx;
				inf_wd  = '{vis: 1'b1, rsum: '0, fv: '0};
				tour_we = root_ok;
				tour_wa = '0;
				tour_wd = '{node: root_idx, depth: '0};
			end
			S_W_ADJ: begin
				fe_ra   = adj_rd.tgt;
				inf_raa = adj_rd.tgt;
			end
			S_W_VISIT: begin
				inf_we  = !inf_rda.vis;
				stk_we  = !inf_rda.vis;
				tour_we = !inf_rda.vis && tl_room;
			end
			S_W_POPD: begin
				tour_we = tl_room;
				tour_wd = '{node: stk_rd.node, depth: sp_m1};
			end
			S_Q_INFO: begin
				rmq_rl  = qk;
				rmq_ra0 = qx;
				rmq_ra1 = qy1[TOUR_AW-1:0];
			end
			S_Q_TABLE: begin
				tour_ra = qpick.pos;
			end
			S_Q_TOUR: begin
				inf_rab = tour_rd.node;
			end
			default: ;
		endcase
	end

	// ---------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_fe_q  <= 1'b1;
			sweep_vis_q <= 1'b1;
			build_q     <= 1'b0;
			ready_q     <= 1'b0;
			swp_q       <= '0;
			ec_q        <= '0;
			tl_q        <= '0;
			sp_q        <= '0;
			i_q         <= '0;
			lvl_q       <= '0;
			fill_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fill_s1 <= (state_q == S_FILL) && fill_go;
			if (out_valid_q && res.ready && state_q != S_Q_OUT) out_valid_q <= 1'b0;
			case (state_q)
				S_SWEEP: begin
					swp_q <= swp_q + NODE_AW'(1);
					if (swp_q == NODE_AW'(MAX_NODES)) begin
						sweep_fe_q  <= 1'b0;
						sweep_vis_q <= 1'b0;
						state_q     <= build_q ? S_ROOT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						w_q <= cmd.edge_weight[WB-1:0];
						case (tlpd_pkg::kind_t'(cmd.kind))
							tlpd_pkg::KIND_CLEAR: begin
								ec_q       <= '0;
								ready_q    <= 1'b0;
								swp_q      <= '0;
								sweep_fe_q <= 1'b1;
								build_q    <= 1'b0;
								state_q    <= S_SWEEP;
							end
							tlpd_pkg::KIND_EDGE: begin
								if (edge_ok) state_q <= S_E_WRA;
							end
							tlpd_pkg::KIND_BUILD: begin
								tl_q        <= '0;
								ready_q     <= 1'b1;
								swp_q       <= '0;
								sweep_vis_q <= 1'b1;
								build_q     <= 1'b1;
								i_q         <= '0;
								lvl_q       <= '0;
								state_q     <= S_SWEEP;
							end
							tlpd_pkg::KIND_QUERY: begin
								rs_anc_q  <= '0;
								rs_dist_q <= '0;
								if (!ready_q) begin
									rs_stat_q <= tlpd_pkg::ST_NOT_BUILT;
									state_q   <= S_Q_OUT;
								end else if (!in_lim(cmd_a_ext, lim) || !in_lim(cmd_b_ext, lim)) begin
									rs_stat_q <= tlpd_pkg::ST_BAD_NODE;
									state_q   <= S_Q_OUT;
								end else begin
									state_q <= S_Q_INFO;
								end
							end
							default: ;
						endcase
					end
				end
				S_E_WRA: begin
					ec_q    <= ec_q + EDGE_AW'(1);
					state_q <= S_E_RDB;
				end
				S_E_RDB: state_q <= S_E_WRB;
				S_E_WRB: begin
					ec_q    <= ec_q + EDGE_AW'(1);
					state_q <= S_IDLE;
				end
				S_ROOT: begin
					if (root_ok) begin
						tl_q       <= TL_W'(1);
						top_node_q <= root_idx;
						top_dist_q <= '0;
						sp_q       <= SP_W'(1);
						state_q    <= S_ROOT_FE;
					end else begin
						state_q <= S_FILL;
					end
				end
				S_ROOT_FE: begin
					top_edge_q <= fe_rd;
					state_q    <= S_W_TOP;
				end
				S_W_TOP: begin
					if (top_done) begin
						sp_q    <= sp_m1;
						state_q <= (sp_q == SP_W'(1)) ? S_FILL : S_W_POPD;
					end else begin
						state_q <= S_W_ADJ;
					end
				end
				S_W_ADJ: begin
					top_edge_q <= adj_rd.nxt;
					v_q        <= adj_rd.tgt;
					w_q        <= adj_rd.w;
					state_q    <= can_push ? S_W_VISIT : S_W_TOP;
				end
				S_W_VISIT: begin
					if (!inf_rda.vis) begin
						top_node_q <= v_q;
						top_edge_q <= fe_rd;
						top_dist_q <= top_dist_q + DWI'(w_q);
						sp_q       <= sp_q + SP_W'(1);
						if (tl_room) tl_q <= tl_q + TL_W'(1);
					end
					state_q <= S_W_TOP;
				end
				S_W_POPD: begin
					top_node_q <= stk_rd.node;
					top_edge_q <= stk_rd.edg;
					top_dist_q <= stk_rd.rsum;
					if (tl_room) tl_q <= tl_q + TL_W'(1);
					state_q <= S_W_TOP;
				end
				S_FILL: begin
					if (fill_go) begin
						i_q <= i_q + TL_W'(1);
					end else begin
						state_q <= S_FILL_GAP;
					end
				end
				S_FILL_GAP: begin
					i_q <= '0;
					if (lvl_q == LVL_W'(TABLE_LEVELS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						lvl_q   <= lvl_q + LVL_W'(1);
						state_q <= S_FILL;
					end
				end
				S_Q_INFO: begin
					da_q <= inf_rda.rsum;
					db_q <= inf_rdb.rsum;
					if (!inf_rda.vis || !inf_rdb.vis) begin
						rs_stat_q <= tlpd_pkg::ST_BAD_NODE;
						state_q   <= S_Q_OUT;
					end else begin
						state_q <= S_Q_TABLE;
					end
				end
				S_Q_TABLE: state_q <= S_Q_TOUR;
				S_Q_TOUR: begin
					anc_q   <= tour_rd.node;
					state_q <= S_Q_DIST;
				end
				S_Q_DIST: begin
					rs_anc_q  <= tlpd_pkg::NODE_W'(anc_q);
					rs_dist_q <= (qd_ext > SW'(tlpd_pkg::DIST_MAX)) ? tlpd_pkg::DIST_MAX
					             : qd_ext[tlpd_pkg::DIST_W-1:0];
					rs_stat_q <= tlpd_pkg::ST_OK;
					state_q   <= S_Q_OUT;
				end
				S_Q_OUT: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// stage 1 of the table fill, the command node latch and the result word
	always_ff @(posedge clk) begin
		i_s1   <= i_q[TOUR_AW-1:0];
		lvl_s1 <= lvl_q;
		if (state_q == S_IDLE && accept) begin
			a_q <= cmd_a_idx;
			b_q <= cmd_b_idx;
		end
		if (state_q == S_Q_OUT && (!out_valid_q || res.ready)) begin
			out_anc_q  <= rs_anc_q;
			out_dist_q <= rs_dist_q;
			out_stat_q <= rs_stat_q;
		end
	end

endmodule

// ===== src/tlpd_checker.sv =====
// tlpd_checker: port-level assertions for tree_lca_path_distance, bound to the top.
// Depends on tlpd_pkg.
module tlpd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [tlpd_pkg::NODE_W-1:0]   res_ancestor,
	input logic [tlpd_pkg::DIST_W-1:0]   res_distance,
	input logic [tlpd_pkg::STATUS_W-1:0] res_status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_ancestor)
		&& $stable(res_distance) && $stable(res_status))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != tlpd_pkg::ST_OK |-> res_ancestor == '0 && res_distance == '0)
		else $error("failed query carries nonzero fields");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_status == tlpd_pkg::ST_OK || res_status == tlpd_pkg::ST_BAD_NODE
		|| res_status == tlpd_pkg::ST_NOT_BUILT)
		else $error("undefined status code");

	a_anc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == tlpd_pkg::ST_OK |-> res_ancestor != '0)
		else $error("ok result without ancestor");

endmodule

bind tree_lca_path_distance tlpd_checker u_tlpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_ancestor (res.ancestor),
	.res_distance (res.distance),
	.res_status   (res.status)
);
